@@ hw/rtl/lif_neuron_layer_step_assert.svh @@
// Assertion macros for the LIF layer block
`ifndef LIF_NEURON_LAYER_STEP_ASSERT_SVH
`define LIF_NEURON_LAYER_STEP_ASSERT_SVH
// implication checked every rising clock edge outside reset
`define LIF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define LIF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

@@ hw/rtl/lif_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lif_pkg
// Types and constants of the LIF neuron layer.
// ----------------------------------------------------------------------------
package lif_pkg;
    localparam logic [1:0] MODE_WIN    = 2'd0;
    localparam logic [1:0] MODE_WREC   = 2'd1;
    localparam logic [1:0] MODE_SAMPLE = 2'd2;
    localparam logic [1:0] MODE_STEP   = 2'd3;

    localparam logic [2:0] REG_LEAK   = 3'd0;
    localparam logic [2:0] REG_THRESH = 3'd1;
    localparam logic [2:0] REG_RESET  = 3'd2;
    localparam logic [2:0] REG_MRATE  = 3'd3;
    localparam logic [2:0] REG_SRATE  = 3'd4;

    typedef struct packed {
        logic [1:0]         mode;
        logic [5:0]         row_index;
        logic [5:0]         column_index;
        logic signed [15:0] value;
    } in_beat_t;

    typedef struct packed {
        logic [5:0]         neuron_index;
        logic               spike;
        logic signed [15:0] membrane_voltage;
        logic signed [15:0] synaptic_current;
        logic               last;
    } out_beat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_VMUL,
        ST_VFIN,
        ST_IMUL,
        ST_MAC_IN,
        ST_MAC_REC,
        ST_MAC_LAST,
        ST_FINISH,
        ST_OUT
    } state_t;
endpackage

@@ hw/rtl/lif_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lif_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module lif_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ hw/rtl/lif_neuron_layer_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lif_neuron_layer_step
// Current-based LIF neuron layer, one time step per step beat.
// ----------------------------------------------------------------------------
// Input beats (in_valid/in_ready) either write a weight or sample (mode 0..2)
// or run one time step (mode 3). Write beats give no output.
// A step beat walks all neurons with one shared multiply-accumulate unit,
// each neuron giving one output beat (out_valid/out_ready) with last set on
// the final neuron. The MAC unit makes one weight read a cycle.
// in_ready is low while a beat is worked on. If the receiver stalls, the
// sequencer holds at the output beat until it is taken.
// Reset (rst_n, async low) clears registers to defaults; membrane, current
// and spike state read zero until the first step ends, samples keep a valid
// bit each. Weight memories are undefined until written. Configuration writes
// (cfg_we/cfg_index/cfg_data) are taken any cycle, meant only when idle.
// ----------------------------------------------------------------------------
`include "lif_neuron_layer_step_assert.svh"
module lif_neuron_layer_step #(
    parameter int NEURON_COUNT = 64,
    parameter int INPUT_COUNT  = 64,
    parameter int VALUE_WIDTH  = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  lif_pkg::in_beat_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output lif_pkg::out_beat_t out_data,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    localparam int NB  = (NEURON_COUNT > 1) ? $clog2(NEURON_COUNT) : 1;
    localparam int IB  = (INPUT_COUNT > 1) ? $clog2(INPUT_COUNT) : 1;
    localparam int KB  = ((IB > NB) ? IB : NB) + 1;
    localparam int SC  = (INPUT_COUNT < 64) ? INPUT_COUNT : 64;
    localparam int SB  = (SC > 1) ? $clog2(SC) : 1;
    localparam int W   = VALUE_WIDTH;
    localparam int CW  = (W > 16) ? W : 16;
    localparam int AW  = 64;
    localparam logic signed [AW-1:0] VMAX = (AW'(1) <<< (W - 1)) - AW'(1);
    localparam logic signed [AW-1:0] VMIN = -VMAX - AW'(1);
    localparam logic signed [AW-1:0] AMAX = (AW'(1) <<< 62) - AW'(1);
    localparam logic signed [AW-1:0] AMIN = -AMAX - AW'(1);

    function automatic logic signed [AW-1:0] sat_v(input logic signed [AW-1:0] x);
        logic signed [AW-1:0] r;
        r = x;
        if (x > VMAX) r = VMAX;
        else if (x < VMIN) r = VMIN;
        return r;
    endfunction

    lif_pkg::state_t state_reg, state_next;

    logic signed [15:0] leak_reg, thresh_reg, rst_v_reg;
    logic [15:0]        mrate_reg, srate_reg;

    lif_pkg::in_beat_t  beat_reg;
    logic [NB-1:0]      n_reg, n_next;
    logic [KB-1:0]      k_reg, k_next;
    logic signed [AW-1:0] acc_reg, acc_next;
    logic signed [W-1:0] vd_reg;
    logic                fire_reg;
    logic signed [AW-1:0] id_reg;
    logic                bank_reg, stepped_reg;
    logic [SC-1:0]      smp_valid_reg;
    lif_pkg::out_beat_t out_reg;

    // shared multiplier
    logic signed [CW:0]     mul_a;
    logic signed [CW+1:0]   mul_b;
    logic signed [2*CW+2:0] mul_p;
    assign mul_p = (2*CW+3)'(mul_a) * (2*CW+3)'(mul_b);

    // weight memories
    logic [NB+IB-1:0]   win_waddr, win_raddr;
    logic [2*NB-1:0]    wrec_waddr, wrec_raddr;
    logic [W-1:0]       win_rdata, wrec_rdata, wdata;
    logic               win_we, wrec_we, smp_we;
    logic               in_acc;
    logic signed [AW-1:0] vin;
    logic [NB-1:0]      rec_k;

    assign in_acc = in_valid && in_ready;
    assign vin    = sat_v(AW'(in_data.value));
    assign wdata  = vin[W-1:0];
    assign win_we  = in_acc && in_data.mode == lif_pkg::MODE_WIN
                     && 32'(in_data.row_index) < NEURON_COUNT
                     && 32'(in_data.column_index) < INPUT_COUNT;
    assign wrec_we = in_acc && in_data.mode == lif_pkg::MODE_WREC
                     && 32'(in_data.row_index) < NEURON_COUNT
                     && 32'(in_data.column_index) < NEURON_COUNT;
    assign smp_we  = in_acc && in_data.mode == lif_pkg::MODE_SAMPLE
                     && 32'(in_data.row_index) < SC;
    assign rec_k      = (state_reg == lif_pkg::ST_MAC_REC) ? k_reg[NB-1:0] : '0;
    assign win_waddr  = {NB'(in_data.row_index), IB'(in_data.column_index)};
    assign wrec_waddr = {NB'(in_data.row_index), NB'(in_data.column_index)};
    assign win_raddr  = {n_reg, k_reg[IB-1:0]};
    assign wrec_raddr = {n_reg, rec_k};

    lif_ram #(.WIDTH(W), .DEPTH(NEURON_COUNT * (1 << IB))) u_win (
        .clk(clk), .we(win_we), .waddr(win_waddr), .wdata(wdata),
        .raddr(win_raddr), .rdata(win_rdata));
    lif_ram #(.WIDTH(W), .DEPTH(NEURON_COUNT * (1 << NB))) u_wrec (
        .clk(clk), .we(wrec_we), .waddr(wrec_waddr), .wdata(wdata),
        .raddr(wrec_raddr), .rdata(wrec_rdata));

    // per-neuron state, input samples and spikes (spikes in two banks: old and new step)
    logic [2*W-1:0]     st_wdata, st_rdata;
    logic               st_we;
    logic [W-1:0]       smp_rdata;
    logic               spk_we, spk_rdata, spk_cur;
    logic [NB:0]        spk_waddr, spk_raddr;

    assign st_we     = (state_reg == lif_pkg::ST_FINISH);
    assign spk_we    = (state_reg == lif_pkg::ST_FINISH);
    assign spk_waddr = {n_reg, ~bank_reg};
    assign spk_raddr = {rec_k, bank_reg};
    assign spk_cur   = stepped_reg & spk_rdata;

    lif_ram #(.WIDTH(2 * W), .DEPTH(NEURON_COUNT)) u_state (
        .clk(clk), .we(st_we), .waddr(n_reg), .wdata(st_wdata),
        .raddr(n_next), .rdata(st_rdata));
    lif_ram #(.WIDTH(W), .DEPTH(1 << SB)) u_smp (
        .clk(clk), .we(smp_we), .waddr(in_data.row_index[SB-1:0]), .wdata(wdata),
        .raddr(k_reg[SB-1:0]), .rdata(smp_rdata));
    lif_ram #(.WIDTH(1), .DEPTH(2 * NEURON_COUNT)) u_spk (
        .clk(clk), .we(spk_we), .waddr(spk_waddr), .wdata(fire_reg),
        .raddr(spk_raddr), .rdata(spk_rdata));

    // reads of per-neuron state
    logic signed [W-1:0] v_cur, i_cur, smp_cur, wt_cur;
    logic [KB-1:0]       k_prev;
    logic                in_phase_prev;
    logic                k_in_smp;
    assign v_cur = stepped_reg ? $signed(st_rdata[2*W-1:W]) : '0;
    assign i_cur = stepped_reg ? $signed(st_rdata[W-1:0]) : '0;

    // ------------------------------------------------------------------ FSM
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lif_pkg::ST_IDLE:
            begin
                if (in_acc) state_next = lif_pkg::ST_LOAD;
            end
            lif_pkg::ST_LOAD:
            begin
                if (beat_reg.mode == lif_pkg::MODE_STEP) state_next = lif_pkg::ST_VMUL;
                else state_next = lif_pkg::ST_IDLE;
            end
            lif_pkg::ST_VMUL:    state_next = lif_pkg::ST_VFIN;
            lif_pkg::ST_VFIN:    state_next = lif_pkg::ST_IMUL;
            lif_pkg::ST_IMUL:    state_next = lif_pkg::ST_MAC_IN;
            lif_pkg::ST_MAC_IN:
            begin
                if (32'(k_reg) == INPUT_COUNT) state_next = lif_pkg::ST_MAC_REC;
            end
            lif_pkg::ST_MAC_REC:
            begin
                if (32'(k_reg) == NEURON_COUNT) state_next = lif_pkg::ST_MAC_LAST;
            end
            lif_pkg::ST_MAC_LAST: state_next = lif_pkg::ST_FINISH;
            lif_pkg::ST_FINISH:   state_next = lif_pkg::ST_OUT;
            lif_pkg::ST_OUT:
            begin
                if (out_ready)
                begin
                    if (32'(n_reg) == NEURON_COUNT - 1) state_next = lif_pkg::ST_IDLE;
                    else state_next = lif_pkg::ST_VMUL;
                end
            end
            default: state_next = lif_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = (state_reg == lif_pkg::ST_IDLE);
        out_valid = (state_reg == lif_pkg::ST_OUT);
        out_data  = out_reg;
    end

    // MAC index: weight for k_reg is read this cycle, used next cycle
    assign k_prev   = k_reg - KB'(1);
    assign k_in_smp = 32'(k_prev) < SC;
    assign smp_cur  = (k_in_smp && smp_valid_reg[k_prev[SB-1:0]])
                      ? $signed(smp_rdata) : '0;
    assign wt_cur   = in_phase_prev ? $signed(win_rdata) : $signed(wrec_rdata);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            lif_pkg::ST_VMUL:
            begin
                mul_a = (CW+1)'($signed({1'b0, mrate_reg}) >>> 0);
                mul_b = (CW+2)'(AW'(leak_reg) - AW'(v_cur) + AW'(i_cur));
            end
            lif_pkg::ST_IMUL:
            begin
                mul_a = (CW+1)'($signed({1'b0, srate_reg}));
                mul_b = (CW+2)'(i_cur);
            end
            default:
            begin
                mul_a = (CW+1)'(smp_cur);
                mul_b = (CW+2)'(wt_cur);
            end
        endcase
    end

    logic signed [AW-1:0] prod_reg;
    logic signed [AW-1:0] term;
    logic                 term_ok;
    logic signed [AW-1:0] vsum, isum;
    logic signed [W-1:0]  v_new, i_new;
    assign vsum = AW'(v_cur) + ((prod_reg + (AW'(1) <<< 15)) >>> 16);
    assign isum = id_reg + ((acc_reg + AW'(128)) >>> 8);
    assign v_new    = fire_reg ? W'(sat_v(AW'(rst_v_reg))) : vd_reg;
    assign i_new    = W'(sat_v(isum));
    assign st_wdata = {v_new, i_new};

    always_comb
    begin
        acc_next = acc_reg;
        term     = '0;
        term_ok  = 1'b0;
        if (state_reg == lif_pkg::ST_VMUL) acc_next = '0;
        if (state_reg == lif_pkg::ST_MAC_IN || state_reg == lif_pkg::ST_MAC_REC)
        begin
            if (k_reg != '0)
            begin
                if (in_phase_prev)
                begin
                    term    = AW'(mul_p);
                    term_ok = 1'b1;
                end
                else if (spk_cur)
                begin
                    term    = AW'(wt_cur) <<< 8;
                    term_ok = 1'b1;
                end
            end
        end
        if (term_ok)
        begin
            acc_next = acc_reg + term;
            if (acc_next > AMAX) acc_next = AMAX;
            else if (acc_next < AMIN) acc_next = AMIN;
        end
    end

    always_comb
    begin
        n_next = n_reg;
        k_next = k_reg;
        priority case (state_reg)
            lif_pkg::ST_LOAD:  begin n_next = '0; k_next = '0; end
            lif_pkg::ST_IMUL:  k_next = KB'(1);
            lif_pkg::ST_MAC_IN:
            begin
                if (32'(k_reg) == INPUT_COUNT) k_next = KB'(1);
                else k_next = k_reg + KB'(1);
            end
            lif_pkg::ST_MAC_REC:
            begin
                if (32'(k_reg) != NEURON_COUNT) k_next = k_reg + KB'(1);
            end
            lif_pkg::ST_OUT:
            begin
                if (out_ready && 32'(n_reg) != NEURON_COUNT - 1)
                begin
                    n_next = n_reg + NB'(1);
                    k_next = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lif_pkg::ST_IDLE;
            leak_reg      <= 16'sd0;
            thresh_reg    <= 16'sd256;
            rst_v_reg     <= 16'sd0;
            mrate_reg     <= 16'd6554;
            srate_reg     <= 16'd13107;
            smp_valid_reg <= '0;
            bank_reg      <= 1'b0;
            stepped_reg   <= 1'b0;
            n_reg         <= '0;
            k_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            k_reg     <= k_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    lif_pkg::REG_LEAK:   leak_reg   <= cfg_data;
                    lif_pkg::REG_THRESH: thresh_reg <= cfg_data;
                    lif_pkg::REG_RESET:  rst_v_reg  <= cfg_data;
                    lif_pkg::REG_MRATE:  mrate_reg  <= cfg_data;
                    lif_pkg::REG_SRATE:  srate_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (smp_we) smp_valid_reg[in_data.row_index[SB-1:0]] <= 1'b1;
            if (state_reg == lif_pkg::ST_OUT && out_ready
                && 32'(n_reg) == NEURON_COUNT - 1)
            begin
                bank_reg    <= ~bank_reg;
                stepped_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc) beat_reg <= in_data;
        in_phase_prev <= (state_reg == lif_pkg::ST_IMUL)
                         || ((state_reg == lif_pkg::ST_MAC_IN) && 32'(k_reg) < INPUT_COUNT);
        prod_reg <= AW'(mul_p);
        acc_reg  <= acc_next;
        unique case (state_reg)
            lif_pkg::ST_VFIN:
            begin
                vd_reg   <= W'(sat_v(vsum));
                fire_reg <= sat_v(vsum) > AW'(thresh_reg);
            end
            lif_pkg::ST_MAC_IN:
            begin
                if (32'(k_reg) == 1)
                    id_reg <= AW'(i_cur) - ((prod_reg + (AW'(1) <<< 15)) >>> 16);
            end
            lif_pkg::ST_FINISH:
            begin
                out_reg.neuron_index     <= 6'(n_reg);
                out_reg.spike            <= fire_reg;
                out_reg.membrane_voltage <= 16'(v_new);
                out_reg.synaptic_current <= 16'(i_new);
                out_reg.last             <= 32'(n_reg) == NEURON_COUNT - 1;
            end
            default: ;
        endcase
    end

    `LIF_ASSERT_IMP(a_excl, out_valid, !in_ready, "output and input both open")
    `LIF_ASSERT_NXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_data),
        "stalled output changed")
    `LIF_ASSERT_IMP(a_last, out_valid && out_data.last, 32'(n_reg) == NEURON_COUNT - 1,
        "last on wrong neuron")
endmodule
